/* design/smt2p_pkg.sv */
// Package: shared widths, constants and sequencer states for the spectrum peak search.
`default_nettype none
package smt2p_pkg;

	localparam int unsigned HALF_BINS_DEF = 512;

	localparam int unsigned SAMP_W  = 16;
	localparam int unsigned MAG_W   = 17;
	localparam int unsigned IDX_W   = 9;
	localparam int unsigned NRG_W   = 32;
	localparam int unsigned RAD_W   = NRG_W + 2;
	localparam int unsigned REM_W   = MAG_W + 1;
	localparam int unsigned STEP_W  = $clog2(MAG_W);

	localparam int unsigned S_DATA_W = 2 * SAMP_W;
	localparam int unsigned M_FLD_W  = 3 * (MAG_W + IDX_W);
	localparam int unsigned M_DATA_W = ((M_FLD_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

/* design/spectrum_magnitude_top_two_peaks_top.sv */
// Top level: per-bin magnitude by shared multiplier and bit-serial root, top-two peak tracking.
//
// Input stream (s_axis): one FFT bin per request, bins 0 .. HALF_BINS-1 in order.
// Output stream (m_axis): one result per bin with its magnitude floor(2*|X|), its bin
// index, and the running largest and second largest magnitudes (DC excluded) with
// their indices. tlast is high on the last bin of the frame; the trackers and the
// bin counter then clear for the next frame.
// Sequence: after a bin is accepted, one multiplier squares the real part, then the
// imaginary part, a restoring square root yields one result bit per cycle, and the
// DONE state loads the output register. The block takes a new bin only after it has
// loaded the result of the previous one.
// The output register holds a result while the sink stalls; the block accepts and
// computes the next bin meanwhile, and waits before loading only if that result is
// still not taken.
// Reset clears the sequencer, the output valid, the bin counter and all trackers.
`default_nettype none
module spectrum_magnitude_top_two_peaks_top
	import smt2p_pkg::*;
#(
	parameter int unsigned HALF_BINS = HALF_BINS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	input  wire logic [S_DATA_W-1:0] s_axis_tdata,  // real_part, imag_part
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic [M_DATA_W-1:0]      m_axis_tdata,  // magnitude, bin_index, peak_magnitude,
	                                                // peak_index, runner_up_magnitude,
	                                                // runner_up_index, zero fill
	output logic                     m_axis_tlast   // frame_done
);

	localparam int unsigned CNT_W = (HALF_BINS > 1) ? $clog2(HALF_BINS) : 1;
	localparam logic [CNT_W-1:0] LAST_BIN = CNT_W'(HALF_BINS - 1);

	state_t state_q, state_d;

	logic [SAMP_W-1:0] re_q, im_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [MAG_W-1:0]  root_q;
	logic [STEP_W-1:0] step_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  best_mag_q, sec_mag_q;
	logic [IDX_W-1:0]  best_idx_q, sec_idx_q;

	logic [M_DATA_W-1:0] out_data_q;
	logic                out_last_q;
	logic                out_valid_q;

	logic                   accept, load;
	logic signed [SAMP_W-1:0] mul_op;
	logic signed [NRG_W-1:0]  prod;
	logic [REM_W+1:0]       cand, trial, diff;
	logic                   fits;
	logic [MAG_W-1:0]       mag;
	logic [IDX_W-1:0]       idx9;
	logic                   last;
	logic [MAG_W-1:0]       nb_mag, ns_mag;
	logic [IDX_W-1:0]       nb_idx, ns_idx;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign load   = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	assign mul_op = (state_q == ST_SQ_IM) ? $signed(im_q) : $signed(re_q);
	assign prod   = mul_op * mul_op;

	assign cand  = {rem_q[REM_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign diff  = cand - trial;
	assign fits  = (cand >= trial);

	assign mag  = root_q;
	assign idx9 = IDX_W'(cnt_q);
	assign last = (cnt_q == LAST_BIN);

	always_comb begin
		nb_mag = best_mag_q;
		nb_idx = best_idx_q;
		ns_mag = sec_mag_q;
		ns_idx = sec_idx_q;
		if (cnt_q != '0) begin
			priority if (mag > best_mag_q) begin
				ns_mag = best_mag_q;
				ns_idx = best_idx_q;
				nb_mag = mag;
				nb_idx = idx9;
			end else if (mag > sec_mag_q) begin
				ns_mag = mag;
				ns_idx = idx9;
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = ST_SQ_RE;
			end
			ST_SQ_RE: state_d = ST_SQ_IM;
			ST_SQ_IM: state_d = ST_ROOT;
			ST_ROOT: begin
				if (step_q == STEP_W'(MAG_W - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// datapath: squares into the radicand, then one root bit per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			re_q <= s_axis_tdata[SAMP_W-1:0];
			im_q <= s_axis_tdata[S_DATA_W-1:SAMP_W];
		end
		unique case (state_q)
			ST_SQ_RE: rad_q <= {prod, 2'b00};
			ST_SQ_IM: begin
				rad_q  <= {rad_q[RAD_W-1:2] + prod, 2'b00};
				rem_q  <= '0;
				root_q <= '0;
				step_q <= '0;
			end
			ST_ROOT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				rem_q  <= fits ? diff[REM_W-1:0] : cand[REM_W-1:0];
				root_q <= {root_q[MAG_W-2:0], fits};
				step_q <= step_q + STEP_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			best_mag_q <= '0;
			best_idx_q <= '0;
			sec_mag_q  <= '0;
			sec_idx_q  <= '0;
		end else if (load) begin
			if (last) begin
				cnt_q      <= '0;
				best_mag_q <= '0;
				best_idx_q <= '0;
				sec_mag_q  <= '0;
				sec_idx_q  <= '0;
			end else begin
				cnt_q      <= cnt_q + CNT_W'(1);
				best_mag_q <= nb_mag;
				best_idx_q <= nb_idx;
				sec_mag_q  <= ns_mag;
				sec_idx_q  <= ns_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= M_DATA_W'({ns_idx, ns_mag, nb_idx, nb_mag, idx9, mag});
			out_last_q <= last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
